FILE: rtl/four_button_mode_selector_macros.svh
// ----------------------------------------------------------------------------
// four_button_mode_selector assertion macros
// Property shorthands clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_BUTTON_MODE_SELECTOR_MACROS_SVH
`define FOUR_BUTTON_MODE_SELECTOR_MACROS_SVH

// Same-cycle implication
`define FBMS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define FBMS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fbms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbms_pkg
// Shared constants, result type and a helper for the four-button mode selector.
// ----------------------------------------------------------------------------
package fbms_pkg;

	localparam int NUM_BTNS = 4;
	localparam int CNT_W    = 9;
	localparam int LIMIT_W  = 8;

	// Lane order
	localparam int BTN_UP    = 0;
	localparam int BTN_DOWN  = 1;
	localparam int BTN_SEND  = 2;
	localparam int BTN_PROTO = 3;

	localparam logic [2:0] MODE_MIN = 3'd1;
	localparam logic [2:0] MODE_MAX = 3'd5;

	localparam logic [1:0] PROTO_UART = 2'd1;
	localparam logic [1:0] PROTO_SPI  = 2'd2;
	localparam logic [1:0] PROTO_MAX  = 2'd3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd20;

	// Action codes
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_RX   = 1'b1;

	typedef struct packed {
		logic [2:0] mode;
		logic [4:0] mode_leds;
		logic [1:0] link_select;
		logic       send_valid;
		logic       send_channel;
		logic [7:0] send_byte;
		logic       error;
	} fbms_result_t;

	// One-hot LED pattern, bit mode-1 set
	function automatic logic [4:0] mode_onehot(input logic [2:0] m);
		logic [4:0] r;
		r = 5'd0;
		case (m)
			3'd1:    r = 5'b00001;
			3'd2:    r = 5'b00010;
			3'd3:    r = 5'b00100;
			3'd4:    r = 5'b01000;
			3'd5:    r = 5'b10000;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/fbms_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbms_lane
// Counter debounce for one button: press and release counters, pressed flag.
// ----------------------------------------------------------------------------
module fbms_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick,
	input  logic                            active,
	input  logic [fbms_pkg::LIMIT_W-1:0]    limit,
	output logic                            fire
);

	logic [fbms_pkg::CNT_W-1:0] press_q, press_nx, press_inc;
	logic [fbms_pkg::CNT_W-1:0] rel_q, rel_nx, rel_inc;
	logic [fbms_pkg::CNT_W-1:0] limit_ext;
	logic                       pressed_q, pressed_nx;

	assign press_inc = press_q + fbms_pkg::CNT_W'(1);
	assign rel_inc   = rel_q + fbms_pkg::CNT_W'(1);
	assign limit_ext = {1'b0, limit};

	// Press stage when active, release stage when idle and held
	always_comb begin
		press_nx   = press_q;
		rel_nx     = rel_q;
		pressed_nx = pressed_q;
		fire       = 1'b0;
		if (tick) begin
			if (active) begin
				if (press_inc > limit_ext) begin
					press_nx = '0;
					if (!pressed_q) begin
						pressed_nx = 1'b1;
						fire       = 1'b1;
					end
				end else begin
					press_nx = press_inc;
				end
			end else if (pressed_q) begin
				if (rel_inc > limit_ext) begin
					rel_nx     = '0;
					pressed_nx = 1'b0;
				end else begin
					rel_nx = rel_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q   <= '0;
			rel_q     <= '0;
			pressed_q <= 1'b0;
		end else begin
			press_q   <= press_nx;
			rel_q     <= rel_nx;
			pressed_q <= pressed_nx;
		end
	end

endmodule

FILE: rtl/fbms_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbms_merge
// Combines lane fire events in button order into mode, protocol and send, or applies a received mode byte.
// ----------------------------------------------------------------------------
module fbms_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 upd,
	input  logic                                 action,
	input  logic [7:0]                           rx_byte,
	input  logic [fbms_pkg::NUM_BTNS-1:0]        fire,
	output fbms_pkg::fbms_result_t               res
);

	logic [2:0] mode_q, mode_up, mode_dn, mode_nx;
	logic [1:0] proto_q, proto_nx;
	logic       error_q, error_nx;
	logic       snd_v, snd_ch;
	logic [7:0] snd_b;

	// Up then down, on the running mode
	assign mode_up = fire[fbms_pkg::BTN_UP] ?
		((mode_q >= fbms_pkg::MODE_MAX) ? fbms_pkg::MODE_MIN : mode_q + 3'd1) : mode_q;
	assign mode_dn = fire[fbms_pkg::BTN_DOWN] ?
		((mode_up <= fbms_pkg::MODE_MIN) ? fbms_pkg::MODE_MAX : mode_up - 3'd1) : mode_up;

	// Next state and send decision
	always_comb begin
		mode_nx  = mode_q;
		proto_nx = proto_q;
		error_nx = error_q;
		snd_v    = 1'b0;
		snd_ch   = 1'b0;
		snd_b    = 8'd0;
		if (action == fbms_pkg::ACT_RX) begin
			if (rx_byte >= 8'(fbms_pkg::MODE_MIN) && rx_byte <= 8'(fbms_pkg::MODE_MAX)) begin
				mode_nx = rx_byte[2:0];
			end else begin
				error_nx = 1'b1;
			end
		end else begin
			mode_nx = mode_dn;
			if (fire[fbms_pkg::BTN_SEND] &&
				(proto_q == fbms_pkg::PROTO_UART || proto_q == fbms_pkg::PROTO_SPI)) begin
				snd_v  = 1'b1;
				snd_ch = (proto_q == fbms_pkg::PROTO_SPI);
				snd_b  = {5'd0, mode_dn};
			end
			if (fire[fbms_pkg::BTN_PROTO]) begin
				proto_nx = (proto_q >= fbms_pkg::PROTO_MAX) ? fbms_pkg::PROTO_UART
					: proto_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= fbms_pkg::MODE_MIN;
			proto_q <= fbms_pkg::PROTO_UART;
			error_q <= 1'b0;
		end else if (upd) begin
			mode_q  <= mode_nx;
			proto_q <= proto_nx;
			error_q <= error_nx;
		end
	end

	// Result of this transaction
	always_comb begin
		res.mode         = mode_nx;
		res.mode_leds    = fbms_pkg::mode_onehot(mode_nx);
		res.link_select  = proto_nx;
		res.send_valid   = snd_v;
		res.send_channel = snd_ch;
		res.send_byte    = snd_b;
		res.error        = error_nx;
	end

endmodule

FILE: rtl/four_button_mode_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_button_mode_selector
// Four debounced buttons select a mode and protocol and trigger a mode send; rx_byte can also set the mode.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// in        in_valid / in_ready    action, btn_*_level, rx_byte
// out       out_valid / out_ready  mode, mode_leds, link_select, send_*, error
// cfg       cfg_we                 cfg_wdata (debounce limit)
//
// One transaction per cycle while in_ready is high; its result is registered and
// appears in the cycle after acceptance. The merge updates state on acceptance; the four lanes do so on tick actions.
// in_ready is high while the output register is empty or being drained.
// Reset leaves mode 1, protocol 1, counters cleared and limit 20.
// ----------------------------------------------------------------------------
`include "four_button_mode_selector_macros.svh"

module four_button_mode_selector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic       btn_up_level,
	input  logic       btn_down_level,
	input  logic       btn_send_level,
	input  logic       btn_proto_level,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] mode,
	output logic [4:0] mode_leds,
	output logic [1:0] link_select,
	output logic       send_valid,
	output logic       send_channel,
	output logic [7:0] send_byte,
	output logic       error,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic [fbms_pkg::LIMIT_W-1:0]  limit_q;
	logic                          in_acc, tick;
	logic [fbms_pkg::NUM_BTNS-1:0] act, fire;
	fbms_pkg::fbms_result_t        res, out_q;
	logic                          out_valid_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign tick     = in_acc && (action == fbms_pkg::ACT_TICK);

	// Debounce limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= fbms_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Active-low pins
	assign act[fbms_pkg::BTN_UP]    = !btn_up_level;
	assign act[fbms_pkg::BTN_DOWN]  = !btn_down_level;
	assign act[fbms_pkg::BTN_SEND]  = !btn_send_level;
	assign act[fbms_pkg::BTN_PROTO] = !btn_proto_level;

	// Debounce lanes
	for (genvar b = 0; b < fbms_pkg::NUM_BTNS; b++) begin : g_lane
		fbms_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.tick   (tick),
			.active (act[b]),
			.limit  (limit_q),
			.fire   (fire[b])
		);
	end

	fbms_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (in_acc),
		.action  (action),
		.rx_byte (rx_byte),
		.fire    (fire),
		.res     (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (in_acc) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign mode         = out_q.mode;
	assign mode_leds    = out_q.mode_leds;
	assign link_select  = out_q.link_select;
	assign send_valid   = out_q.send_valid;
	assign send_channel = out_q.send_channel;
	assign send_byte    = out_q.send_byte;
	assign error        = out_q.error;

	// Checks
	`FBMS_ASSERT_IMP(a_mode_range, out_valid, (mode >= fbms_pkg::MODE_MIN && mode <= fbms_pkg::MODE_MAX), "mode out of range")
	`FBMS_ASSERT_IMP(a_leds_onehot, out_valid, $onehot(mode_leds), "mode LEDs not one-hot")
	`FBMS_ASSERT_IMP(a_send_byte, out_valid && send_valid, send_byte == 8'(mode), "send byte off")
	`FBMS_ASSERT_NXT(a_error_sticky, error, error, "error flag dropped")

endmodule
